FILE: design/health_alert_tracker_assert.svh
// Assertion macros used by the health alert tracker checker.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef HEALTH_ALERT_TRACKER_ASSERT_SVH
`define HEALTH_ALERT_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("health_alert_tracker: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("health_alert_tracker: next-cycle check failed");

`endif

FILE: design/hat_pkg.sv
// Types and constants for the health alert tracker.
// No dependencies; used by the top level and its checker.
package hat_pkg;

  // Request kinds.
  localparam logic [1:0] REQ_STATUS  = 2'd0;
  localparam logic [1:0] REQ_ALERT   = 2'd1;
  localparam logic [1:0] REQ_RECOVER = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  // Probe status codes.
  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_UP      = 2'd1;
  localparam logic [1:0] ST_DOWN    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [1:0] CFG_ALERT_CD   = 2'd1;
  localparam logic [1:0] CFG_RECOVER_CD = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  THRESHOLD_RST  = 8'd3;
  localparam logic [31:0] ALERT_CD_RST   = 32'd300000;
  localparam logic [31:0] RECOVER_CD_RST = 32'd60000;

  // Milliseconds to seconds: floor(x / 1000) = (x * ceil(2^38 / 1000)) >> 38,
  // exact for every 32-bit x since the rounding error times x stays below 2^38.
  localparam int          MAGIC_W      = 29;
  localparam logic [28:0] MS_DIV_MAGIC = 29'd274877907;
  localparam int          MS_DIV_SHIFT = 38;
  localparam int          PROD_W       = 32 + MAGIC_W;
  localparam int          DOWN_W       = 23;

  // One result between the state update and the output register.
  typedef struct packed {
    logic        alert_due;
    logic        recovery_due;
    logic [15:0] failures;
    logic        alert_active;
    logic [1:0]  status_now;
    logic [31:0] down_ms;
    logic [15:0] latency;
  } hat_result_t;

endpackage

FILE: design/health_alert_tracker.sv
// Health alert tracker: one result per item, three-register pipeline.
// An accepted item passes through the input, middle and output registers in turn.
// Throughput: one item per cycle while out_stall does not hold the pipeline; the state update is combinational.
// A multiply-by-reciprocal stage between the middle and output registers forms the seconds.
// Reset (rst_n low, synchronous) empties the pipeline, clears all tracking state
// and returns the configuration registers to 3, 300000 and 60000.
module health_alert_tracker (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_now_ms,
  input  logic [1:0]  in_probe_status,
  input  logic [15:0] in_probe_latency,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_alert_due,
  output logic        out_recovery_due,
  output logic [15:0] out_failures,
  output logic        out_alert_active,
  output logic [1:0]  out_status_now,
  output logic [22:0] out_downtime_seconds,
  output logic [15:0] out_latency_out,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Pipeline valid bits and moves.
  logic in_v_r, in_v_nxt;
  logic mid_v_r, mid_v_nxt;
  logic out_v_r, out_v_nxt;
  logic in_take, mid_ld, out_ld;

  // Input register payload.
  logic [1:0]  req_r;
  logic [31:0] now_r;
  logic [1:0]  probe_r;
  logic [15:0] lat_in_r;

  // Configuration registers.
  logic [7:0]  thr_r;
  logic [31:0] alert_cd_r;
  logic [31:0] recov_cd_r;

  // Tracking state.
  logic [1:0]  cur_r, cur_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [31:0] fft_r, fft_nxt;
  logic        ffv_r, ffv_nxt;
  logic [31:0] last_r, last_nxt;
  logic        lav_r, lav_nxt;
  logic        sent_r, sent_nxt;
  logic        active_r, active_nxt;
  logic        dsv_r, dsv_nxt;
  logic [31:0] saved_r, saved_nxt;
  logic [15:0] stlat_r, stlat_nxt;

  // Working values of the state update.
  logic [1:0]  st_in;
  logic        st_fail;
  logic        cur_fail;
  logic        nxt_fail;
  logic [15:0] cnt_inc;
  logic [31:0] since_alert;
  logic        alert_blk;
  logic        recov_blk;

  hat_pkg::hat_result_t mid_nxt, mid_r;

  // Output register and seconds conversion.
  logic [hat_pkg::PROD_W-1:0] prod;
  logic                       o_alert_r, o_recov_r, o_active_r;
  logic [15:0]                o_fail_r, o_lat_r;
  logic [1:0]                 o_status_r;
  logic [hat_pkg::DOWN_W-1:0] o_down_r;

  // Stage moves: each stage loads when it is empty or its contents move on.
  assign out_ld    = mid_v_r && (!out_v_r || !out_stall);
  assign mid_ld    = in_v_r && (!mid_v_r || out_ld);
  assign in_stall  = in_v_r && !mid_ld;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_v_nxt  = in_take ? 1'b1 : (mid_ld ? 1'b0 : in_v_r);
    mid_v_nxt = mid_ld ? 1'b1 : (out_ld ? 1'b0 : mid_v_r);
    out_v_nxt = out_ld ? 1'b1 : (out_stall ? out_v_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      mid_v_r <= mid_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Capture an accepted beat.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r    <= in_req_type;
      now_r    <= in_now_ms;
      probe_r  <= in_probe_status;
      lat_in_r <= in_probe_latency;
    end
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= hat_pkg::THRESHOLD_RST;
      alert_cd_r <= hat_pkg::ALERT_CD_RST;
      recov_cd_r <= hat_pkg::RECOVER_CD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hat_pkg::CFG_THRESHOLD:  thr_r      <= cfg_data[7:0];
        hat_pkg::CFG_ALERT_CD:   alert_cd_r <= cfg_data;
        hat_pkg::CFG_RECOVER_CD: recov_cd_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Apply the request to the tracking state.
  always_comb begin
    st_in    = (probe_r > hat_pkg::ST_DOWN) ? hat_pkg::ST_UNKNOWN : probe_r;
    st_fail  = (st_in == hat_pkg::ST_DOWN) || (st_in == hat_pkg::ST_UNKNOWN);
    cur_fail = (cur_r == hat_pkg::ST_DOWN) || (cur_r == hat_pkg::ST_UNKNOWN);
    cnt_inc  = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;

    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    fft_nxt    = fft_r;
    ffv_nxt    = ffv_r;
    last_nxt   = last_r;
    lav_nxt    = lav_r;
    sent_nxt   = sent_r;
    active_nxt = active_r;
    dsv_nxt    = dsv_r;
    saved_nxt  = saved_r;
    stlat_nxt  = stlat_r;

    case (req_r)
      hat_pkg::REQ_STATUS: begin
        stlat_nxt = lat_in_r;
        if (cur_r != st_in) begin
          cur_nxt = st_in;
          if (st_fail) begin
            cnt_nxt = cnt_inc;
            // The first failure of a run stamps the start of downtime.
            if (cnt_inc == 16'd1) begin
              fft_nxt = now_r;
              ffv_nxt = 1'b1;
            end
          end else if ((st_in == hat_pkg::ST_UP) && cur_fail && !sent_r) begin
            // Quick recovery before any alert: drop the failure run.
            ffv_nxt = 1'b0;
            cnt_nxt = 16'd0;
          end
        end else if (st_fail) begin
          cnt_nxt = cnt_inc;
        end
      end
      hat_pkg::REQ_ALERT: begin
        sent_nxt   = 1'b1;
        active_nxt = 1'b1;
        last_nxt   = now_r;
        lav_nxt    = 1'b1;
        dsv_nxt    = 1'b1;
      end
      hat_pkg::REQ_RECOVER: begin
        if (ffv_r) begin
          saved_nxt = now_r - fft_r;
        end
        cnt_nxt    = 16'd0;
        sent_nxt   = 1'b0;
        ffv_nxt    = 1'b0;
        dsv_nxt    = 1'b0;
        active_nxt = 1'b0;
        last_nxt   = now_r;
        lav_nxt    = 1'b1;
      end
      default: begin
        cur_nxt    = hat_pkg::ST_UNKNOWN;
        cnt_nxt    = 16'd0;
        ffv_nxt    = 1'b0;
        lav_nxt    = 1'b0;
        sent_nxt   = 1'b0;
        active_nxt = 1'b0;
        dsv_nxt    = 1'b0;
        saved_nxt  = 32'd0;
        stlat_nxt  = 16'd0;
      end
    endcase
  end

  // Result fields from the updated state.
  // Downtime in milliseconds is kept raw; seconds are formed at the output.
  always_comb begin
    nxt_fail    = (cur_nxt == hat_pkg::ST_DOWN) || (cur_nxt == hat_pkg::ST_UNKNOWN);
    since_alert = now_r - last_nxt;
    alert_blk   = lav_nxt && (since_alert < alert_cd_r);
    recov_blk   = lav_nxt && (since_alert < recov_cd_r);

    mid_nxt.alert_due    = nxt_fail && (cnt_nxt >= {8'd0, thr_r}) && !alert_blk;
    mid_nxt.recovery_due = (cur_nxt == hat_pkg::ST_UP) && sent_nxt && dsv_nxt && !recov_blk;
    mid_nxt.failures     = cnt_nxt;
    mid_nxt.alert_active = active_nxt;
    mid_nxt.status_now   = cur_nxt;
    mid_nxt.down_ms      = ffv_nxt ? (now_r - fft_nxt) : saved_nxt;
    mid_nxt.latency      = stlat_nxt;
  end

  // Tracking state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= hat_pkg::ST_UNKNOWN;
      cnt_r    <= 16'd0;
      fft_r    <= 32'd0;
      ffv_r    <= 1'b0;
      last_r   <= 32'd0;
      lav_r    <= 1'b0;
      sent_r   <= 1'b0;
      active_r <= 1'b0;
      dsv_r    <= 1'b0;
      saved_r  <= 32'd0;
      stlat_r  <= 16'd0;
    end else if (mid_ld) begin
      cur_r    <= cur_nxt;
      cnt_r    <= cnt_nxt;
      fft_r    <= fft_nxt;
      ffv_r    <= ffv_nxt;
      last_r   <= last_nxt;
      lav_r    <= lav_nxt;
      sent_r   <= sent_nxt;
      active_r <= active_nxt;
      dsv_r    <= dsv_nxt;
      saved_r  <= saved_nxt;
      stlat_r  <= stlat_nxt;
    end
  end

  // Middle register.
  always_ff @(posedge clk) begin
    if (mid_ld) begin
      mid_r <= mid_nxt;
    end
  end

  // Milliseconds to seconds by reciprocal multiplication.
  assign prod = hat_pkg::PROD_W'(mid_r.down_ms) * hat_pkg::PROD_W'(hat_pkg::MS_DIV_MAGIC);

  // Output register.
  always_ff @(posedge clk) begin
    if (out_ld) begin
      o_alert_r  <= mid_r.alert_due;
      o_recov_r  <= mid_r.recovery_due;
      o_fail_r   <= mid_r.failures;
      o_active_r <= mid_r.alert_active;
      o_status_r <= mid_r.status_now;
      o_down_r   <= prod[hat_pkg::MS_DIV_SHIFT +: hat_pkg::DOWN_W];
      o_lat_r    <= mid_r.latency;
    end
  end

  assign out_valid            = out_v_r;
  assign out_alert_due        = o_alert_r;
  assign out_recovery_due     = o_recov_r;
  assign out_failures         = o_fail_r;
  assign out_alert_active     = o_active_r;
  assign out_status_now       = o_status_r;
  assign out_downtime_seconds = o_down_r;
  assign out_latency_out      = o_lat_r;

endmodule

FILE: design/hat_checker.sv
// Port-level checks for the health alert tracker, bound to the top level.
// Depends on hat_pkg and the macros in health_alert_tracker_assert.svh.
`include "health_alert_tracker_assert.svh"

module hat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_alert_due,
  input logic        out_recovery_due,
  input logic [15:0] out_failures,
  input logic        out_alert_active,
  input logic [1:0]  out_status_now,
  input logic [22:0] out_downtime_seconds,
  input logic [15:0] out_latency_out
);

  // A stalled result beat stays and holds its payload.
  `HAT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_failures) && $stable(out_downtime_seconds) && $stable(out_latency_out))

  // An alert is never due while the target reports up.
  `HAT_ASSERT_NOW(a_alert_not_up, clk, rst_n, out_valid && out_alert_due, out_status_now != hat_pkg::ST_UP)

  // A recovery notice needs the target up and an alert still active.
  `HAT_ASSERT_NOW(a_recov_ctx, clk, rst_n, out_valid && out_recovery_due, (out_status_now == hat_pkg::ST_UP) && out_alert_active)

endmodule

bind health_alert_tracker hat_checker u_hat_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_alert_due        (out_alert_due),
  .out_recovery_due     (out_recovery_due),
  .out_failures         (out_failures),
  .out_alert_active     (out_alert_active),
  .out_status_now       (out_status_now),
  .out_downtime_seconds (out_downtime_seconds),
  .out_latency_out      (out_latency_out)
);
